// File: rtl/core/dpfsm_pkg.sv
package dpfsm_pkg;

  // Table and swap area geometry
  localparam int HEAP_ENTRIES    = 128;
  localparam int SWAP_BLOCKS     = 1024;
  localparam int BLOCKS_PER_PAGE = 4;
  localparam int SWAP_SLOTS      = SWAP_BLOCKS / BLOCKS_PER_PAGE;

  localparam int ENTRY_W = $clog2(HEAP_ENTRIES);
  localparam int SLOT_W  = $clog2(SWAP_SLOTS);
  localparam int BOFS_W  = $clog2(BLOCKS_PER_PAGE);

  // One scan pass covers both the table and the slot bitmap
  localparam int SCAN_LEN = (HEAP_ENTRIES > SWAP_SLOTS) ? HEAP_ENTRIES : SWAP_SLOTS;
  localparam int SCAN_W   = $clog2(SCAN_LEN + 1);

  // Field widths
  localparam int PAGE_W  = 27;
  localparam int ESLOT_W = 7;
  localparam int STAMP_W = 32;
  localparam int BLOCK_W = 10;
  localparam int CNT_W   = 8;
  localparam int LIMIT_W = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 8'hFF;

  // Item kinds carried in tuser
  localparam logic KIND_REG   = 1'b0;
  localparam logic KIND_FAULT = 1'b1;

  // Input item, last field in the low bits
  typedef struct packed {
    logic [STAMP_W-1:0] now;
    logic [ESLOT_W-1:0] entry_slot;
    logic [PAGE_W-1:0]  page_number;
  } item_t;

  localparam int ITEM_W     = $bits(item_t);
  localparam int TDATA_IN_W = ((ITEM_W + 7) / 8) * 8;

  // Result item, last field in the low bits
  typedef struct packed {
    logic [CNT_W-1:0]   resident_count;
    logic               swap_full;
    logic [BLOCK_W-1:0] swap_in_block;
    logic               swapped_in;
    logic [BLOCK_W-1:0] evicted_block;
    logic [PAGE_W-1:0]  evicted_page;
    logic               evicted;
    logic [ESLOT_W-1:0] hit_entry;
    logic               is_heap;
  } res_t;

  localparam int RES_W       = $bits(res_t);
  localparam int TDATA_OUT_W = ((RES_W + 7) / 8) * 8;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_run;
    logic home_rd;
    logic reg_commit;
    logic flt_commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/core/dpfsm_ctrl.sv
module dpfsm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  input  dpfsm_pkg::dp_sts_t sts_i,
  output logic              in_ready_o,
  output dpfsm_pkg::cmd_t   cmd_o
);
  import dpfsm_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SCAN      = 6'b000010,
    ST_HOME_RD   = 6'b000100,
    ST_FLT_APPLY = 6'b001000,
    ST_REG_RD    = 6'b010000,
    ST_REG_APPLY = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Sequencer: accept; a fault scans, reads swap home, commits; a register reads swap home, commits
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_kind_i == KIND_FAULT) ? ST_SCAN : ST_REG_RD;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_HOME_RD;
        end
      end
      ST_HOME_RD: begin
        cmd_o.home_rd = 1'b1;
        state_d       = ST_FLT_APPLY;
      end
      ST_FLT_APPLY: begin
        if (sts_i.out_free) begin
          cmd_o.flt_commit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_REG_RD: begin
        cmd_o.home_rd = 1'b1;
        state_d       = ST_REG_APPLY;
      end
      ST_REG_APPLY: begin
        if (sts_i.out_free) begin
          cmd_o.reg_commit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/dpfsm_dp.sv
module dpfsm_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dpfsm_pkg::cmd_t                 cmd_i,
  output dpfsm_pkg::dp_sts_t              sts_o,
  input  dpfsm_pkg::item_t                item_i,
  input  logic                            kind_i,
  input  logic                            cfg_we_i,
  input  logic [dpfsm_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  output dpfsm_pkg::res_t                 res_o,
  output logic                            res_valid_o,
  input  logic                            res_ready_i
);
  import dpfsm_pkg::*;

  // Captured transaction
  item_t item_q;
  logic  kind_q;

  // Architectural state
  logic [LIMIT_W-1:0]      limit_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [HEAP_ENTRIES-1:0] valid_q, loaded_q, home_set_q;
  logic [SWAP_SLOTS-1:0]   used_q;

  logic [PAGE_W-1:0]  pt_mem    [HEAP_ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [HEAP_ENTRIES];
  logic [SLOT_W-1:0]  home_mem  [HEAP_ENTRIES];

  logic [PAGE_W-1:0]  pt_rd_q;
  logic [STAMP_W-1:0] st_rd_q;
  logic [SLOT_W-1:0]  home_rd_q;

  // Scan state
  logic [SCAN_W-1:0]  cnt_q;
  logic               rd_vld_q;
  logic [ENTRY_W-1:0] rd_idx_q;
  logic               hit_found_q;
  logic [ENTRY_W-1:0] hit_idx_q;
  logic               vic_found_q;
  logic [ENTRY_W-1:0] vic_idx_q;
  logic [STAMP_W-1:0] vic_stamp_q;
  logic [PAGE_W-1:0]  vic_page_q;
  logic               slot_found_q;
  logic [SLOT_W-1:0]  slot_idx_q;

  // Result register
  res_t res_q, res_d;
  logic res_valid_q;

  logic               tbl_rd, slot_chk, cnt_run, match, cand;
  logic [ENTRY_W-1:0] tbl_idx, e_idx, home_addr;
  logic [SLOT_W-1:0]  chk_slot;
  logic               e_ok, commit;
  logic               h_loaded, fresh, need_ev, do_ev, ev_full, sw_in;
  logic [CNT_W-1:0]   c_ev, c_flt, c_reg;

  // Scan addressing
  assign tbl_rd    = cmd_i.scan_run && (cnt_q < SCAN_W'(HEAP_ENTRIES));
  assign tbl_idx   = cnt_q[ENTRY_W-1:0];
  assign slot_chk  = cmd_i.scan_run && (cnt_q < SCAN_W'(SWAP_SLOTS));
  assign chk_slot  = cnt_q[SLOT_W-1:0];
  assign cnt_run   = cmd_i.scan_run && (cnt_q != SCAN_W'(SCAN_LEN));
  assign match     = rd_vld_q && valid_q[rd_idx_q] && (pt_rd_q == item_q.page_number);
  assign cand      = rd_vld_q && valid_q[rd_idx_q] && loaded_q[rd_idx_q] &&
                     (!vic_found_q || (st_rd_q < vic_stamp_q));

  assign e_idx     = ENTRY_W'(item_q.entry_slot);
  assign e_ok      = int'(item_q.entry_slot) < HEAP_ENTRIES;
  assign home_addr = (kind_q == KIND_FAULT) ? hit_idx_q : e_idx;
  assign commit    = cmd_i.reg_commit || cmd_i.flt_commit;

  // Fault resolution; a loaded entry never holds a swap slot
  assign h_loaded = loaded_q[hit_idx_q];
  assign fresh    = hit_found_q && !h_loaded;
  assign need_ev  = fresh && (count_q >= limit_q) && vic_found_q;
  assign do_ev    = need_ev && slot_found_q;
  assign ev_full  = need_ev && !slot_found_q;
  assign sw_in    = fresh && home_set_q[hit_idx_q];

  // Resident count, saturating both ways
  assign c_ev  = (do_ev && count_q != '0) ? count_q - 1'b1 : count_q;
  assign c_flt = (fresh && c_ev != CNT_MAX) ? c_ev + 1'b1 : c_ev;
  assign c_reg = (e_ok && loaded_q[e_idx] && count_q != '0) ? count_q - 1'b1 : count_q;

  always_comb begin
    count_d = count_q;
    if (cmd_i.reg_commit) begin
      count_d = c_reg;
    end else if (cmd_i.flt_commit) begin
      count_d = c_flt;
    end
  end

  // Result assembly
  always_comb begin
    res_d = '0;
    if (cmd_i.reg_commit) begin
      res_d.resident_count = c_reg;
    end else begin
      res_d.is_heap        = hit_found_q;
      res_d.hit_entry      = ESLOT_W'(hit_idx_q);
      res_d.evicted        = do_ev;
      res_d.evicted_page   = do_ev ? vic_page_q : '0;
      res_d.evicted_block  = do_ev ? BLOCK_W'({slot_idx_q, {BOFS_W{1'b0}}}) : '0;
      res_d.swapped_in     = sw_in;
      res_d.swap_in_block  = sw_in ? BLOCK_W'({home_rd_q, {BOFS_W{1'b0}}}) : '0;
      res_d.swap_full      = ev_full;
      res_d.resident_count = c_flt;
    end
  end

  // Page number table
  always_ff @(posedge clk_i) begin
    if (cmd_i.reg_commit && e_ok) begin
      pt_mem[e_idx] <= item_q.page_number;
    end
    if (tbl_rd) begin
      pt_rd_q <= pt_mem[tbl_idx];
    end
  end

  // Load stamp table
  always_ff @(posedge clk_i) begin
    if (cmd_i.flt_commit && hit_found_q) begin
      stamp_mem[hit_idx_q] <= item_q.now;
    end
    if (tbl_rd) begin
      st_rd_q <= stamp_mem[tbl_idx];
    end
  end

  // Swap home table, meaningful only where home_set_q is set
  always_ff @(posedge clk_i) begin
    if (cmd_i.flt_commit && do_ev) begin
      home_mem[vic_idx_q] <= slot_idx_q;
    end
    if (cmd_i.home_rd) begin
      home_rd_q <= home_mem[home_addr];
    end
  end

  // Captured item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (commit) begin
      res_q <= res_d;
    end
  end

  // Scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q       <= KIND_REG;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      hit_found_q  <= 1'b0;
      hit_idx_q    <= '0;
      vic_found_q  <= 1'b0;
      vic_idx_q    <= '0;
      vic_stamp_q  <= '0;
      vic_page_q   <= '0;
      slot_found_q <= 1'b0;
      slot_idx_q   <= '0;
    end else if (cmd_i.load) begin
      kind_q       <= kind_i;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      hit_found_q  <= 1'b0;
      hit_idx_q    <= '0;
      vic_found_q  <= 1'b0;
      slot_found_q <= 1'b0;
      slot_idx_q   <= '0;
    end else begin
      if (cnt_run) begin
        cnt_q <= cnt_q + 1'b1;
      end
      rd_vld_q <= tbl_rd;
      rd_idx_q <= tbl_idx;
      // lowest matching entry wins
      if (match && !hit_found_q) begin
        hit_found_q <= 1'b1;
        hit_idx_q   <= rd_idx_q;
      end
      // oldest loaded entry, strict compare keeps the lowest index on ties
      if (cand) begin
        vic_found_q <= 1'b1;
        vic_idx_q   <= rd_idx_q;
        vic_stamp_q <= st_rd_q;
        vic_page_q  <= pt_rd_q;
      end
      // first free swap slot
      if (slot_chk && !slot_found_q && !used_q[chk_slot]) begin
        slot_found_q <= 1'b1;
        slot_idx_q   <= chk_slot;
      end
    end
  end

  // Entry flags, slot bitmap, count and limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      loaded_q   <= '0;
      home_set_q <= '0;
      used_q     <= '0;
      count_q    <= '0;
      limit_q    <= LIMIT_RESET;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.reg_commit && e_ok) begin
        if (home_set_q[e_idx]) begin
          used_q[home_rd_q] <= 1'b0;
        end
        home_set_q[e_idx] <= 1'b0;
        loaded_q[e_idx]   <= 1'b0;
        valid_q[e_idx]    <= 1'b1;
      end
      if (cmd_i.flt_commit) begin
        if (do_ev) begin
          used_q[slot_idx_q]    <= 1'b1;
          home_set_q[vic_idx_q] <= 1'b1;
          loaded_q[vic_idx_q]   <= 1'b0;
        end
        // slot of the faulting page differs from the new victim slot
        if (sw_in) begin
          used_q[home_rd_q]     <= 1'b0;
          home_set_q[hit_idx_q] <= 1'b0;
        end
        if (hit_found_q) begin
          loaded_q[hit_idx_q] <= 1'b1;
        end
      end
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (commit) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign sts_o.scan_done = (cnt_q == SCAN_W'(SCAN_LEN)) && !rd_vld_q;
  assign sts_o.out_free  = !res_valid_q || res_ready_i;
  assign res_o           = res_q;
  assign res_valid_o     = res_valid_q;

endmodule

// File: rtl/core/demand_paging_fifo_swap_manager.sv
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata: item, tuser: kind
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: result
// cfg       in   cfg_we_i                         cfg_wdata_i: resident_limit
//
// A register transaction reads the swap home, then commits to the result register.
// A fault first runs a scan: one shared scan counter walks the page table
// memories and the 256-entry swap slot bitmap, one entry and one slot a cycle.
// Reset clears all flags, the slot bitmap and the count; no clearing pass.
// One transaction is in flight; the next is accepted while a result waits in
// the output register, and its commit holds until that result is taken.
module demand_paging_fifo_swap_manager (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // page_number[26:0], entry_slot[33:27], now[65:34], zero[71:66]
  input  logic [dpfsm_pkg::TDATA_IN_W-1:0]    s_axis_tdata_i,
  // kind[0]
  input  logic [0:0]                          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // is_heap[0], hit_entry[7:1], evicted[8], evicted_page[35:9],
  // evicted_block[45:36], swapped_in[46], swap_in_block[56:47],
  // swap_full[57], resident_count[65:58], zero[71:66]
  output logic [dpfsm_pkg::TDATA_OUT_W-1:0]   m_axis_tdata_o,
  input  logic                                cfg_we_i,
  input  logic [dpfsm_pkg::LIMIT_W-1:0]       cfg_wdata_i
);
  import dpfsm_pkg::*;

  cmd_t    cmd;
  dp_sts_t dp_sts;
  item_t   item;
  res_t    res;

  assign item = item_t'(s_axis_tdata_i[ITEM_W-1:0]);

  dpfsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i[0]),
    .sts_i      (dp_sts),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  dpfsm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (dp_sts),
    .item_i      (item),
    .kind_i      (s_axis_tuser_i[0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = TDATA_OUT_W'(res);

endmodule

// File: rtl/core/dpfsm_chk.sv
module dpfsm_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid_i,
  input logic                                s_axis_tready_o,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i,
  input logic [dpfsm_pkg::TDATA_OUT_W-1:0]   m_axis_tdata_o
);
  import dpfsm_pkg::*;

  res_t res;

  assign res = res_t'(m_axis_tdata_o[RES_W-1:0]);

  // Result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed under stall");

  // One transaction in flight: no acceptance right after another
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  // Eviction and swap-in only for heap pages, never with a full swap area
  a_evict_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (res.evicted || res.swapped_in || res.swap_full) |->
      res.is_heap && !(res.evicted && res.swap_full))
    else $error("inconsistent eviction flags");

  // Resident pages never exceed the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> int'(res.resident_count) <= HEAP_ENTRIES)
    else $error("resident count out of range");

endmodule

bind demand_paging_fifo_swap_manager dpfsm_chk u_chk (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import dpfsm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int REPORT_MAX     = 10;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   s_valid   = 1'b0;
  logic [TDATA_IN_W-1:0]  s_data    = '0;
  logic [0:0]             s_user    = KIND_REG;
  logic                   m_ready   = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [LIMIT_W-1:0]     cfg_wdata = '0;
  logic                   s_ready;
  logic                   m_valid;
  logic [TDATA_OUT_W-1:0] m_data;

  demand_paging_fifo_swap_manager dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow of the paging state
  logic [PAGE_W-1:0]  tbl_page  [HEAP_ENTRIES];
  logic [STAMP_W-1:0] tbl_stamp [HEAP_ENTRIES];
  bit                 tbl_valid [HEAP_ENTRIES];
  bit                 tbl_loaded[HEAP_ENTRIES];
  bit                 home_set  [HEAP_ENTRIES];
  int                 home_slot [HEAP_ENTRIES];
  bit                 slot_busy [SWAP_SLOTS];
  logic [CNT_W-1:0]   resident  = '0;
  logic [LIMIT_W-1:0] limit_now = LIMIT_RESET;

  res_t               paging_results_q[$];
  res_t               seen_result;
  res_t               want_result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;
  int mismatches    = 0;
  int n_items       = 0;
  int n_faults      = 0;
  int n_outside     = 0;
  int n_restamps    = 0;
  int n_evictions   = 0;
  int n_swap_ins    = 0;
  int n_limits      = 0;
  logic [STAMP_W-1:0] tick = '0;

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got)
      flag_mismatch($sformatf("result %0d field %s expected %0h got %0h",
                              n_items - paging_results_q.size(), name, want, got));
  endfunction

  function automatic void free_swap_home(int e);
    if (home_set[e]) slot_busy[home_slot[e]] = 1'b0;
    home_set[e] = 1'b0;
  endfunction

  // Expected outcome of one transaction; updates the shadow state
  function automatic res_t compute_paging_result(logic kind, logic [PAGE_W-1:0] pg,
                                                 logic [ESLOT_W-1:0] es,
                                                 logic [STAMP_W-1:0] stamp);
    res_t r;
    int   i;
    int   hit;
    int   victim;
    int   slot;
    r      = '0;
    hit    = -1;
    victim = -1;
    slot   = -1;

    // register: entry becomes valid, unloaded, no swap home
    if (kind == KIND_REG) begin
      if (tbl_loaded[es] && resident != 0) resident--;
      free_swap_home(es);
      tbl_page[es]   = pg;
      tbl_loaded[es] = 1'b0;
      tbl_valid[es]  = 1'b1;
      r.resident_count = resident;
      return r;
    end

    n_faults++;
    for (i = 0; i < HEAP_ENTRIES; i++)
      if (hit < 0 && tbl_valid[i] && tbl_page[i] == pg) hit = i;
    if (hit < 0) begin
      n_outside++;
      r.resident_count = resident;
      return r;
    end
    r.is_heap   = 1'b1;
    r.hit_entry = ESLOT_W'(hit);

    if (tbl_loaded[hit]) begin
      n_restamps++;
      tbl_stamp[hit]   = stamp;
      r.resident_count = resident;
      return r;
    end

    // oldest loaded entry goes to the first free slot, lowest index on ties
    if (resident >= limit_now) begin
      for (i = 0; i < HEAP_ENTRIES; i++)
        if (tbl_valid[i] && tbl_loaded[i] && (victim < 0 || tbl_stamp[i] < tbl_stamp[victim]))
          victim = i;
      for (i = 0; i < SWAP_SLOTS; i++)
        if (slot < 0 && !slot_busy[i]) slot = i;
      if (victim >= 0) begin
        if (slot < 0) begin
          r.swap_full = 1'b1;
        end else begin
          free_swap_home(victim);
          slot_busy[slot]    = 1'b1;
          home_set[victim]   = 1'b1;
          home_slot[victim]  = slot;
          tbl_loaded[victim] = 1'b0;
          if (resident != 0) resident--;
          r.evicted       = 1'b1;
          r.evicted_page  = tbl_page[victim];
          r.evicted_block = BLOCK_W'(slot * BLOCKS_PER_PAGE);
          n_evictions++;
        end
      end
    end

    if (home_set[hit]) begin
      r.swapped_in    = 1'b1;
      r.swap_in_block = BLOCK_W'(home_slot[hit] * BLOCKS_PER_PAGE);
      free_swap_home(hit);
      n_swap_ins++;
    end

    tbl_stamp[hit]  = stamp;
    tbl_loaded[hit] = 1'b1;
    if (resident != CNT_MAX) resident++;
    r.resident_count = resident;
    return r;
  endfunction

  // Mostly slow-moving ticks (increment 0 gives equal stamps), some jumps
  function automatic logic [STAMP_W-1:0] next_stamp();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) return $urandom();
    if (roll == 6) return '0;
    if (roll == 7) return '1;
    tick += $urandom_range(3);
    return tick;
  endfunction

  function automatic logic [PAGE_W-1:0] pick_page();
    int roll;
    int e;
    roll = $urandom_range(99);
    e    = $urandom_range(HEAP_ENTRIES - 1);
    if (roll < 60) return PAGE_W'($urandom());
    if (roll < 80 && tbl_valid[e]) return tbl_page[e];
    if (roll < 90) return PAGE_W'($urandom_range(15));
    return {PAGE_W{1'b1}} - PAGE_W'($urandom_range(3));
  endfunction

  task automatic send_item(input logic kind, input logic [PAGE_W-1:0] pg,
                           input logic [ESLOT_W-1:0] es, input logic [STAMP_W-1:0] stamp);
    item_t it;
    it.page_number = pg;
    it.entry_slot  = es;
    it.now         = stamp;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {{(TDATA_IN_W - ITEM_W){1'b0}}, it};
    s_user  <= kind;
    do @(posedge clk); while (!s_ready);
    paging_results_q.push_back(compute_paging_result(kind, pg, es, stamp));
    n_items++;
  endtask

  // Limit changes only with nothing in flight
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk);
    s_valid <= 1'b0;
    while (paging_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_now = value;
    n_limits++;
  endtask

  // Random traffic focused on a window of entries
  task automatic run_working_set(input logic [LIMIT_W-1:0] lim, input int n, input int span);
    int   base;
    int   roll;
    int   e;
    logic kind;
    logic [PAGE_W-1:0] pg;
    write_limit(lim);
    base = $urandom_range(HEAP_ENTRIES - span);
    repeat (n) begin
      roll = $urandom_range(99);
      e    = base + $urandom_range(span - 1);
      if (roll < 22) begin
        kind = KIND_REG;
        if ($urandom_range(19) == 0) e = $urandom_range(HEAP_ENTRIES - 1);
        pg = pick_page();
      end else begin
        kind = KIND_FAULT;
        pg   = (roll < 92 && tbl_valid[e]) ? tbl_page[e] : PAGE_W'($urandom());
        // entry field is don't-care on faults
        e    = $urandom_range(HEAP_ENTRIES - 1);
      end
      send_item(kind, pg, ESLOT_W'(e), next_stamp());
    end
  endtask

  task automatic test_directed_cases();
    // fault on an empty table
    send_item(KIND_FAULT, 27'h0000123, 7'd0,   32'h0);
    // extremes of page and entry, duplicate page in two entries
    send_item(KIND_REG,   27'h0,       7'd0,   32'h0);
    send_item(KIND_REG,   27'h7FFFFFF, 7'd127, 32'h0);
    send_item(KIND_REG,   27'h55,      7'd5,   32'h0);
    send_item(KIND_REG,   27'h55,      7'd3,   32'h0);
    // lowest duplicate hits, then restamp of a loaded page
    send_item(KIND_FAULT, 27'h55,      7'd127, 32'h10);
    send_item(KIND_FAULT, 27'h55,      7'd0,   32'h20);
    send_item(KIND_FAULT, 27'h0,       7'd5,   32'hFFFFFFFF);
    send_item(KIND_FAULT, 27'h7FFFFFF, 7'd0,   32'h0);
    // single resident page: every miss evicts
    write_limit(8'd1);
    send_item(KIND_REG,   27'h66,      7'd64,  32'h0);
    send_item(KIND_FAULT, 27'h66,      7'd0,   32'h5);
    send_item(KIND_FAULT, 27'h55,      7'd0,   32'h20);
    send_item(KIND_FAULT, 27'h7FFFFFF, 7'd0,   32'h6);
    // reregister a loaded entry and an entry holding a swap slot
    send_item(KIND_REG,   27'h77,      7'd127, 32'h0);
    send_item(KIND_REG,   27'h67,      7'd64,  32'h0);
    // equal stamps: lowest index is the victim
    write_limit(8'd3);
    send_item(KIND_REG,   27'h80,      7'd10,  32'h0);
    send_item(KIND_REG,   27'h81,      7'd11,  32'h0);
    send_item(KIND_FAULT, 27'h80,      7'd0,   32'h20);
    send_item(KIND_FAULT, 27'h81,      7'd0,   32'h20);
    send_item(KIND_FAULT, 27'h55,      7'd0,   32'h21);
    send_item(KIND_FAULT, 27'h0000124, 7'd127, 32'h22);
  endtask

  task automatic test_single_resident();
    run_working_set(8'd1, 50, 4);
  endtask

  task automatic test_small_limits();
    int lim;
    repeat (2) begin
      lim = $urandom_range(2, 12);
      run_working_set(LIMIT_W'(lim), 85, lim + $urandom_range(1, 8));
    end
  endtask

  task automatic test_no_eviction_limit();
    run_working_set(8'd128, 50, HEAP_ENTRIES);
  endtask

  task automatic test_unstructured();
    int pick;
    pick = $urandom_range(2);
    write_limit(pick == 0 ? 8'd1 : pick == 1 ? 8'd128 : LIMIT_W'($urandom_range(1, 128)));
    repeat (45)
      send_item($urandom_range(1) ? KIND_FAULT : KIND_REG,
                $urandom_range(1) ? pick_page() : PAGE_W'($urandom()),
                ESLOT_W'($urandom()), $urandom());
  endtask

  // Receiver backpressure
  always @(negedge clk) m_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Result checker
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      seen_result = res_t'(m_data[RES_W-1:0]);
      if (paging_results_q.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: %h", seen_result));
      end else begin
        want_result = paging_results_q.pop_front();
        compare_field("is_heap",        want_result.is_heap,        seen_result.is_heap);
        compare_field("hit_entry",      want_result.hit_entry,      seen_result.hit_entry);
        compare_field("evicted",        want_result.evicted,        seen_result.evicted);
        compare_field("evicted_page",   want_result.evicted_page,   seen_result.evicted_page);
        compare_field("evicted_block",  want_result.evicted_block,  seen_result.evicted_block);
        compare_field("swapped_in",     want_result.swapped_in,     seen_result.swapped_in);
        compare_field("swap_in_block",  want_result.swap_in_block,  seen_result.swap_in_block);
        compare_field("swap_full",      want_result.swap_full,      seen_result.swap_full);
        compare_field("resident_count", want_result.resident_count, seen_result.resident_count);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               stall_cycles, paging_results_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      test_single_resident();
      test_small_limits();
      test_no_eviction_limit();
      test_unstructured();
    end

    // drain, then watch for stray results
    @(negedge clk);
    s_valid <= 1'b0;
    while (paging_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d transactions over %0d limit settings: %0d faults, %0d outside heap,",
             n_items, n_limits, n_faults, n_outside);
    $display("  %0d restamps, %0d evictions, %0d swap-ins; %0d mismatches",
             n_restamps, n_evictions, n_swap_ins, mismatches);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/dpfsm_pkg.sv
rtl/core/dpfsm_ctrl.sv
rtl/core/dpfsm_dp.sv
rtl/core/demand_paging_fifo_swap_manager.sv
rtl/core/dpfsm_chk.sv
dv/tb.sv
